### design/smft_pkg.sv
package smft_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int CORNERS       = 4;
    localparam int COORD_BITS    = 24;
    localparam int EIDX_W        = $clog2(TABLE_ENTRIES);
    localparam int CIDX_W        = $clog2(CORNERS);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int CADDR_W       = EIDX_W + CIDX_W;
    localparam int CORNER_W      = 3 * COORD_BITS;
    localparam int META_W        = 16 + 16 + 16 + 1 + 32;
    localparam int W_NEW         = 6554;
    localparam int W_OLD         = 58982;
    localparam logic [31:0] AGE_LIMIT_RESET = 32'd1000000;

    typedef enum logic [1:0] {
        CMD_CORNER = 2'd0,
        CMD_SWEEP  = 2'd1,
        CMD_READ   = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_ADDED   = 3'd0,
        ST_MERGED  = 3'd1,
        ST_DROPPED = 3'd2,
        ST_SWEPT   = 3'd3,
        ST_READ    = 3'd4,
        ST_EMPTY   = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CENT,
        S_MREQ,
        S_MCHK,
        S_BLEND_RD,
        S_BLEND_MUL,
        S_BLEND_WR,
        S_APPEND,
        S_SWEEP_RD,
        S_SWEEP_CHK,
        S_SWEEP_CRD,
        S_SWEEP_CWR,
        S_READ_WAIT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]             command;
        logic [1:0]             corner_index;
        logic [3:0]             entry_index;
        logic signed [COORD_BITS-1:0] corner_x;
        logic signed [COORD_BITS-1:0] corner_y;
        logic signed [COORD_BITS-1:0] corner_z;
        logic [15:0]            surface_confidence;
        logic [15:0]            edge_confidence;
        logic                   is_traversable;
        logic [31:0]            time_stamp;
    } req_t;

    typedef struct packed {
        logic [2:0]             status;
        logic [15:0]            surface_id;
        logic signed [COORD_BITS-1:0] out_x;
        logic signed [COORD_BITS-1:0] out_y;
        logic signed [COORD_BITS-1:0] out_z;
        logic [15:0]            out_confidence;
        logic [15:0]            out_edge_confidence;
        logic                   out_traversable;
        logic [31:0]            out_last_seen;
        logic [4:0]             removed_count;
        logic [4:0]             live_count;
    } rsp_t;

    typedef struct packed {
        logic [15:0] id;
        logic [15:0] conf;
        logic [15:0] edge_conf;
        logic        trav;
        logic [31:0] seen;
    } meta_t;

endpackage

### design/smft_ram.sv
module smft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### design/surface_map_fusion_table.sv
// surface map fusion table, one request in flight at a time (busy high while working)
// corner items 0..2 are stored without raising busy and give no result; a read returns one corner
// an ending corner forms the centroid and checks the entries in turn, then appends, drops
// when the table is full, or merges by blending all four corners into the matching entry
// a sweep walks the entries and moves each kept entry down over removed ones; done strobes
// in the last busy cycle; reset (rst_n, async low) clears state, count, next id, age limit, indices
module surface_map_fusion_table
    import smft_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  req_t        request,
    output logic        done,
    output rsp_t        result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // ---------------- configuration ----------------
    logic [31:0] age_limit_reg;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? age_limit_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            age_limit_reg <= AGE_LIMIT_RESET;
        end
        else if (psel && penable && pwrite && paddr == 2'd0)
        begin
            age_limit_reg <= pwdata;
        end
    end

    // ---------------- memories ----------------
    logic                 c_we;
    logic [CADDR_W-1:0]   c_waddr, c_raddr;
    logic [CORNER_W-1:0]  c_wdata, c_rdata;
    logic                 m_we;
    logic [EIDX_W-1:0]    m_waddr, m_raddr;
    logic [META_W-1:0]    m_wdata, m_rdata;
    meta_t                m_rd;

    smft_ram #(.WIDTH(CORNER_W), .DEPTH(TABLE_ENTRIES * CORNERS)) u_corner_ram (
        .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
        .raddr(c_raddr), .rdata(c_rdata)
    );

    smft_ram #(.WIDTH(META_W), .DEPTH(TABLE_ENTRIES)) u_meta_ram (
        .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
        .raddr(m_raddr), .rdata(m_rdata)
    );

    assign m_rd = meta_t'(m_rdata);

    // ---------------- state ----------------
    state_t state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [15:0]         id_reg, id_next;
    // pending observation corners (fixed-place registers)
    logic [CORNER_W-1:0] pend_reg [CORNERS];
    req_t                req_reg;
    logic [CNT_W-1:0]    idx_reg, idx_next;      // entry walk index
    logic [CNT_W-1:0]    keep_reg, keep_next;    // sweep write index
    logic [CNT_W-1:0]    rem_reg, rem_next;
    logic [CIDX_W:0]     ci_reg, ci_next;        // corner walk index
    logic signed [COORD_BITS-1:0] cx_reg, cy_reg;
    logic signed [COORD_BITS-1:0] c0x_reg, c1x_reg, c1y_reg;
    logic signed [COORD_BITS+16:0] prod_reg [3];
    rsp_t                rsp_next;
    logic                done_next;

    assign busy = (state_reg != S_IDLE);

    logic accept;
    assign accept = start && !busy;

    // centroid sum, 2 extra bits
    logic signed [COORD_BITS+1:0] sum_x, sum_y;
    always_comb
    begin
        sum_x = '0;
        sum_y = '0;
        for (int i = 0; i < CORNERS; i++)
        begin
            sum_x = sum_x + (COORD_BITS+2)'(signed'(pend_reg[i][3*COORD_BITS-1 -: COORD_BITS]));
            sum_y = sum_y + (COORD_BITS+2)'(signed'(pend_reg[i][2*COORD_BITS-1 -: COORD_BITS]));
        end
    end

    // coordinate slices of memory read data
    function automatic logic signed [COORD_BITS-1:0] crd(input logic [CORNER_W-1:0] w,
                                                          input int k);
        crd = w[CORNER_W-1-k*COORD_BITS -: COORD_BITS];
    endfunction

    logic [CIDX_W-1:0] ci_lo;
    assign ci_lo = ci_reg[CIDX_W-1:0];

    // blend sum
    logic [CORNER_W-1:0] blended;
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            logic signed [COORD_BITS+17:0] s;
            s = (COORD_BITS+18)'(prod_reg[k]) + (COORD_BITS+18)'(signed'(18'sd32768));
            blended[CORNER_W-1-k*COORD_BITS -: COORD_BITS] = s[COORD_BITS+15:16];
        end
    end

    logic [31:0] age;
    assign age = req_reg.time_stamp - m_rd.seen;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        id_next    = id_reg;
        idx_next   = idx_reg;
        keep_next  = keep_reg;
        rem_next   = rem_reg;
        ci_next    = ci_reg;
        done_next  = 1'b0;
        rsp_next   = '0;
        c_we = 1'b0; c_waddr = '0; c_wdata = '0; c_raddr = '0;
        m_we = 1'b0; m_waddr = '0; m_wdata = '0; m_raddr = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd_t'(request.command))
                        CMD_CORNER:
                            if (request.corner_index == 2'd3)
                                state_next = S_CENT;
                        CMD_SWEEP:
                        begin
                            idx_next = '0; keep_next = '0; rem_next = '0;
                            state_next = S_SWEEP_RD;
                        end
                        CMD_READ:
                        begin
                            c_raddr = {request.entry_index[EIDX_W-1:0], request.corner_index};
                            m_raddr = request.entry_index[EIDX_W-1:0];
                            state_next = S_READ_WAIT;
                        end
                        default: ;
                    endcase
                end
            end
            S_CENT:
            begin
                idx_next = '0;
                ci_next = '0;
                state_next = S_MREQ;
            end
            S_MREQ:
            begin
                if (idx_reg >= count_reg)
                    state_next = S_APPEND;
                else
                begin
                    // read corner0 then corner1 then corner2, one per visit to S_MREQ
                    c_raddr = {idx_reg[EIDX_W-1:0], ci_lo};
                    state_next = S_MCHK;
                end
            end
            S_MCHK:
            begin
                if (ci_reg == 2)
                begin
                    if (cx_reg > c1x_reg && cx_reg < c0x_reg &&
                        cy_reg > crd(c_rdata, 1) && cy_reg < c1y_reg)
                    begin
                        ci_next = '0;
                        state_next = S_BLEND_RD;
                    end
                    else
                    begin
                        ci_next = '0;
                        idx_next = idx_reg + 1'b1;
                        state_next = S_MREQ;
                    end
                end
                else
                begin
                    ci_next = ci_reg + 1'b1;
                    state_next = S_MREQ;
                end
            end
            S_BLEND_RD:
            begin
                c_raddr = {idx_reg[EIDX_W-1:0], ci_lo};
                m_raddr = idx_reg[EIDX_W-1:0];
                state_next = S_BLEND_MUL;
            end
            S_BLEND_MUL:
            begin
                m_raddr = idx_reg[EIDX_W-1:0];
                state_next = S_BLEND_WR;
            end
            S_BLEND_WR:
            begin
                m_raddr = idx_reg[EIDX_W-1:0];
                c_we = 1'b1;
                c_waddr = {idx_reg[EIDX_W-1:0], ci_lo};
                c_wdata = blended;
                if (ci_reg == CORNERS - 1)
                begin
                    meta_t nm;
                    nm = m_rd;
                    nm.edge_conf = 16'((17'(m_rd.edge_conf) + 17'(req_reg.edge_confidence)
                                        + 17'd1) >> 1);
                    if (req_reg.surface_confidence > m_rd.conf)
                        nm.conf = req_reg.surface_confidence;
                    nm.trav = m_rd.trav & req_reg.is_traversable;
                    nm.seen = req_reg.time_stamp;
                    m_we = 1'b1;
                    m_waddr = idx_reg[EIDX_W-1:0];
                    m_wdata = nm;
                    rsp_next.status = ST_MERGED;
                    rsp_next.surface_id = m_rd.id;
                    rsp_next.live_count = 5'(count_reg);
                    done_next = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    ci_next = ci_reg + 1'b1;
                    state_next = S_BLEND_RD;
                end
            end
            S_APPEND:
            begin
                if (count_reg < TABLE_ENTRIES)
                begin
                    meta_t nm;
                    c_we = 1'b1;
                    c_waddr = {count_reg[EIDX_W-1:0], ci_lo};
                    c_wdata = pend_reg[ci_lo];
                    if (ci_reg == CORNERS - 1)
                    begin
                        nm.id = id_reg;
                        nm.conf = req_reg.surface_confidence;
                        nm.edge_conf = req_reg.edge_confidence;
                        nm.trav = req_reg.is_traversable;
                        nm.seen = req_reg.time_stamp;
                        m_we = 1'b1;
                        m_waddr = count_reg[EIDX_W-1:0];
                        m_wdata = nm;
                        id_next = id_reg + 16'd1;
                        count_next = count_reg + 1'b1;
                        ci_next = '0;
                        rsp_next.status = ST_ADDED;
                        rsp_next.surface_id = id_reg;
                        rsp_next.live_count = 5'(count_reg + 1'b1);
                        done_next = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                        ci_next = ci_reg + 1'b1;
                end
                else
                begin
                    rsp_next.status = ST_DROPPED;
                    rsp_next.live_count = 5'(count_reg);
                    done_next = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_SWEEP_RD:
            begin
                if (idx_reg >= count_reg)
                begin
                    count_next = keep_reg;
                    rsp_next.status = ST_SWEPT;
                    rsp_next.removed_count = 5'(rem_reg);
                    rsp_next.live_count = 5'(keep_reg);
                    done_next = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    m_raddr = idx_reg[EIDX_W-1:0];
                    state_next = S_SWEEP_CHK;
                end
            end
            S_SWEEP_CHK:
            begin
                if (age > age_limit_reg)
                begin
                    rem_next = rem_reg + 1'b1;
                    idx_next = idx_reg + 1'b1;
                    state_next = S_SWEEP_RD;
                end
                else if (keep_reg == idx_reg)
                begin
                    keep_next = keep_reg + 1'b1;
                    idx_next = idx_reg + 1'b1;
                    state_next = S_SWEEP_RD;
                end
                else
                begin
                    m_we = 1'b1;
                    m_waddr = keep_reg[EIDX_W-1:0];
                    m_wdata = m_rdata;
                    ci_next = '0;
                    state_next = S_SWEEP_CRD;
                end
            end
            S_SWEEP_CRD:
            begin
                c_raddr = {idx_reg[EIDX_W-1:0], ci_lo};
                state_next = S_SWEEP_CWR;
            end
            S_SWEEP_CWR:
            begin
                c_we = 1'b1;
                c_waddr = {keep_reg[EIDX_W-1:0], ci_lo};
                c_wdata = c_rdata;
                if (ci_reg == CORNERS - 1)
                begin
                    ci_next = '0;
                    keep_next = keep_reg + 1'b1;
                    idx_next = idx_reg + 1'b1;
                    state_next = S_SWEEP_RD;
                end
                else
                begin
                    ci_next = ci_reg + 1'b1;
                    state_next = S_SWEEP_CRD;
                end
            end
            S_READ_WAIT:
            begin
                if (req_reg.entry_index < 4'(count_reg) || count_reg == TABLE_ENTRIES)
                begin
                    rsp_next.status = ST_READ;
                    rsp_next.surface_id = m_rd.id;
                    rsp_next.out_x = crd(c_rdata, 0);
                    rsp_next.out_y = crd(c_rdata, 1);
                    rsp_next.out_z = crd(c_rdata, 2);
                    rsp_next.out_confidence = m_rd.conf;
                    rsp_next.out_edge_confidence = m_rd.edge_conf;
                    rsp_next.out_traversable = m_rd.trav;
                    rsp_next.out_last_seen = m_rd.seen;
                end
                else
                    rsp_next.status = ST_EMPTY;
                rsp_next.live_count = 5'(count_reg);
                done_next = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            id_reg    <= '0;
            idx_reg   <= '0;
            keep_reg  <= '0;
            rem_reg   <= '0;
            ci_reg    <= '0;
            done      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            id_reg    <= id_next;
            idx_reg   <= idx_next;
            keep_reg  <= keep_next;
            rem_reg   <= rem_next;
            ci_reg    <= ci_next;
            done      <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        result <= rsp_next;
        if (accept)
        begin
            req_reg <= request;
            if (cmd_t'(request.command) == CMD_CORNER)
                pend_reg[request.corner_index] <= {request.corner_x, request.corner_y,
                                                   request.corner_z};
        end
        if (state_reg == S_CENT)
        begin
            cx_reg <= sum_x[COORD_BITS+1:2];
            cy_reg <= sum_y[COORD_BITS+1:2];
        end
        if (state_reg == S_MCHK && ci_reg == 0)
            c0x_reg <= crd(c_rdata, 0);
        if (state_reg == S_MCHK && ci_reg == 1)
        begin
            c1x_reg <= crd(c_rdata, 0);
            c1y_reg <= crd(c_rdata, 1);
        end
        if (state_reg == S_BLEND_MUL)
        begin
            for (int k = 0; k < 3; k++)
                prod_reg[k] <= (COORD_BITS+17)'(crd(pend_reg[ci_lo], k)) * 17'sd6554
                             + (COORD_BITS+17)'(crd(c_rdata, k)) * 17'sd58982;
        end
    end

endmodule

### design/smft_checker.sv
module smft_checker
    import smft_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input rsp_t result
);

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done outside a busy span");

    a_busy_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy without a request");

    a_no_double: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("two results back to back");

    a_live: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.live_count <= TABLE_ENTRIES)
        else $error("live count out of range");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.status <= ST_EMPTY)
        else $error("bad status");

endmodule

bind surface_map_fusion_table smft_checker u_smft_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done), .result(result)
);

### verif/surface_map_fusion_table_tb.sv
`timescale 1ns / 1ps

module surface_map_fusion_table_tb;
    import smft_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    req_t        request;
    logic        done;
    rsp_t        result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    surface_map_fusion_table dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // register index of the age limit
    localparam logic [1:0] REG_AGE_LIMIT = 2'd0;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // shadow copy of the surface table
    logic signed [COORD_BITS-1:0] tab_x [TABLE_ENTRIES*CORNERS];
    logic signed [COORD_BITS-1:0] tab_y [TABLE_ENTRIES*CORNERS];
    logic signed [COORD_BITS-1:0] tab_z [TABLE_ENTRIES*CORNERS];
    meta_t                        tab_meta [TABLE_ENTRIES];
    logic signed [COORD_BITS-1:0] obs_x [CORNERS];
    logic signed [COORD_BITS-1:0] obs_y [CORNERS];
    logic signed [COORD_BITS-1:0] obs_z [CORNERS];
    int unsigned                  live_entries;
    logic [15:0]                  id_next;
    logic [31:0]                  age_limit;

    rsp_t        expected_rsp_q [$];
    int unsigned mismatch_count;
    logic [31:0] clock_now;
    int          center_x [12];
    int          center_y [12];

    // fixed-point blend: new*0.1 + old*0.9 rounded, floor division
    function automatic logic signed [COORD_BITS-1:0] blend_coord(longint nv, longint ov);
        longint acc;
        acc = nv * W_NEW + ov * W_OLD + 32768;
        return COORD_BITS'(acc >>> 16);
    endfunction

    // predicts the response (if any) of one accepted request
    function automatic void predict_table(req_t r);
        rsp_t        rsp;
        longint      sx;
        longint      sy;
        longint      cx;
        longint      cy;
        int          hit;
        int          b;
        int unsigned keep;
        int unsigned removed;
        logic [31:0] age;
        rsp = '0;
        case (cmd_t'(r.command))
            CMD_CORNER:
            begin
                obs_x[r.corner_index] = r.corner_x;
                obs_y[r.corner_index] = r.corner_y;
                obs_z[r.corner_index] = r.corner_z;
                if (r.corner_index != 2'd3)
                    return;
                sx = 0;
                sy = 0;
                for (int i = 0; i < CORNERS; i++)
                begin
                    sx += longint'(obs_x[i]);
                    sy += longint'(obs_y[i]);
                end
                cx = sx >>> 2;
                cy = sy >>> 2;
                hit = -1;
                for (int i = 0; i < int'(live_entries); i++)
                begin
                    b = i * CORNERS;
                    if (hit < 0 && cx > tab_x[b+1] && cx < tab_x[b] &&
                        cy > tab_y[b+2] && cy < tab_y[b+1])
                        hit = i;
                end
                if (hit >= 0)
                begin
                    for (int i = 0; i < CORNERS; i++)
                    begin
                        b = hit * CORNERS + i;
                        tab_x[b] = blend_coord(obs_x[i], tab_x[b]);
                        tab_y[b] = blend_coord(obs_y[i], tab_y[b]);
                        tab_z[b] = blend_coord(obs_z[i], tab_z[b]);
                    end
                    tab_meta[hit].edge_conf = 16'((17'(tab_meta[hit].edge_conf)
                                              + 17'(r.edge_confidence) + 17'd1) >> 1);
                    if (r.surface_confidence > tab_meta[hit].conf)
                        tab_meta[hit].conf = r.surface_confidence;
                    tab_meta[hit].trav &= r.is_traversable;
                    tab_meta[hit].seen = r.time_stamp;
                    rsp.status = ST_MERGED;
                    rsp.surface_id = tab_meta[hit].id;
                end
                else if (live_entries < TABLE_ENTRIES)
                begin
                    for (int i = 0; i < CORNERS; i++)
                    begin
                        b = live_entries * CORNERS + i;
                        tab_x[b] = obs_x[i];
                        tab_y[b] = obs_y[i];
                        tab_z[b] = obs_z[i];
                    end
                    tab_meta[live_entries] = '{id_next, r.surface_confidence,
                                               r.edge_confidence, r.is_traversable,
                                               r.time_stamp};
                    rsp.status = ST_ADDED;
                    rsp.surface_id = id_next;
                    id_next++;
                    live_entries++;
                end
                else
                    rsp.status = ST_DROPPED;
            end
            CMD_SWEEP:
            begin
                keep = 0;
                removed = 0;
                for (int i = 0; i < int'(live_entries); i++)
                begin
                    age = r.time_stamp - tab_meta[i].seen;
                    if (age > age_limit)
                        removed++;
                    else
                    begin
                        tab_meta[keep] = tab_meta[i];
                        for (int k = 0; k < CORNERS; k++)
                        begin
                            tab_x[keep*CORNERS+k] = tab_x[i*CORNERS+k];
                            tab_y[keep*CORNERS+k] = tab_y[i*CORNERS+k];
                            tab_z[keep*CORNERS+k] = tab_z[i*CORNERS+k];
                        end
                        keep++;
                    end
                end
                live_entries = keep;
                rsp.status = ST_SWEPT;
                rsp.removed_count = 5'(removed);
            end
            CMD_READ:
            begin
                if (r.entry_index < live_entries)
                begin
                    b = r.entry_index * CORNERS + r.corner_index;
                    rsp.status = ST_READ;
                    rsp.surface_id = tab_meta[r.entry_index].id;
                    rsp.out_x = tab_x[b];
                    rsp.out_y = tab_y[b];
                    rsp.out_z = tab_z[b];
                    rsp.out_confidence = tab_meta[r.entry_index].conf;
                    rsp.out_edge_confidence = tab_meta[r.entry_index].edge_conf;
                    rsp.out_traversable = tab_meta[r.entry_index].trav;
                    rsp.out_last_seen = tab_meta[r.entry_index].seen;
                end
                else
                    rsp.status = ST_EMPTY;
            end
            default:
                return;
        endcase
        rsp.live_count = 5'(live_entries);
        expected_rsp_q = {expected_rsp_q, rsp};
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatch_count++;
        $display("%0t: %s got %h expected %h", $time, what, got, want);
    endtask

    // response checker: every done pulse pops the oldest expectation
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && done)
        begin
            if (expected_rsp_q.size() == 0)
                report_mismatch("unexpected response status", 32'(result.status), 32'h0);
            else
            begin
                want = expected_rsp_q.pop_front();
                if (result.status !== want.status)
                    report_mismatch("status", 32'(result.status), 32'(want.status));
                if (result.surface_id !== want.surface_id)
                    report_mismatch("surface_id", 32'(result.surface_id), 32'(want.surface_id));
                if (result.out_x !== want.out_x)
                    report_mismatch("out_x", 32'(result.out_x), 32'(want.out_x));
                if (result.out_y !== want.out_y)
                    report_mismatch("out_y", 32'(result.out_y), 32'(want.out_y));
                if (result.out_z !== want.out_z)
                    report_mismatch("out_z", 32'(result.out_z), 32'(want.out_z));
                if (result.out_confidence !== want.out_confidence)
                    report_mismatch("out_confidence", 32'(result.out_confidence),
                                    32'(want.out_confidence));
                if (result.out_edge_confidence !== want.out_edge_confidence)
                    report_mismatch("out_edge_confidence", 32'(result.out_edge_confidence),
                                    32'(want.out_edge_confidence));
                if (result.out_traversable !== want.out_traversable)
                    report_mismatch("out_traversable", 32'(result.out_traversable),
                                    32'(want.out_traversable));
                if (result.out_last_seen !== want.out_last_seen)
                    report_mismatch("out_last_seen", result.out_last_seen, want.out_last_seen);
                if (result.removed_count !== want.removed_count)
                    report_mismatch("removed_count", 32'(result.removed_count),
                                    32'(want.removed_count));
                if (result.live_count !== want.live_count)
                    report_mismatch("live_count", 32'(result.live_count), 32'(want.live_count));
            end
        end
    end

    // one request: random gap, then hold start until the block takes it
    task automatic send_request(req_t r);
        int gap;
        gap = $urandom_range(0, 18);
        if ($urandom_range(0, 3) == 0)
            gap = 0;   // stretches of back-to-back requests
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start   <= 1'b1;
        request <= r;
        do
            @(posedge clk);
        while (busy);
        predict_table(r);
    endtask

    task automatic drain_requests();
        @(negedge clk);
        start <= 1'b0;
        wait (expected_rsp_q.size() == 0);
        // a trailing corner item gives no response; let the block settle
        repeat (200) @(negedge clk);
    endtask

    task automatic set_age_limit(logic [31:0] value);
        drain_requests();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= REG_AGE_LIMIT;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        age_limit = value;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic req_t make_request(cmd_t cmd, logic [1:0] ci, logic [3:0] ei,
                                          logic [23:0] x, logic [23:0] y, logic [23:0] z);
        req_t r;
        r.command = cmd;
        r.corner_index = ci;
        r.entry_index = ei;
        r.corner_x = x;
        r.corner_y = y;
        r.corner_z = z;
        r.surface_confidence = 16'($urandom);
        r.edge_confidence = 16'($urandom);
        r.is_traversable = 1'($urandom);
        r.time_stamp = clock_now;
        return r;
    endfunction

    // rectangle around (cx, cy), corners in the order the match test expects
    task automatic send_quad(int cx, int cy, int w, int h, logic [15:0] conf,
                             logic [15:0] edge_c, logic trav);
        req_t r;
        int   xs [CORNERS];
        int   ys [CORNERS];
        xs = '{cx + w, cx - w, cx - w, cx + w};
        ys = '{cy + h, cy + h, cy - h, cy - h};
        for (int i = 0; i < CORNERS; i++)
        begin
            r = make_request(CMD_CORNER, 2'(i), 4'($urandom), 24'(xs[i]), 24'(ys[i]),
                             24'($urandom));
            r.surface_confidence = conf;
            r.edge_confidence = edge_c;
            r.is_traversable = trav;
            send_request(r);
        end
    endtask

    // extremes, merge of extreme corners, reads, empty read, unused command, wrapped age
    task automatic test_directed();
        req_t r;
        logic [23:0] xs [CORNERS];
        logic [23:0] ys [CORNERS];
        xs = '{24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF};
        ys = '{24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000};
        clock_now = 32'd5000;
        for (int i = 0; i < CORNERS; i++)
        begin
            r = make_request(CMD_CORNER, 2'(i), 4'hF, xs[i], ys[i],
                             (i % 2) ? 24'h800000 : 24'h7FFFFF);
            r.surface_confidence = 16'h0000;
            r.edge_confidence = 16'hFFFF;
            r.is_traversable = 1'b1;
            send_request(r);
        end
        // a centroid inside the extreme entry merges with extreme opposite values
        send_quad(0, 0, 1000, 1000, 16'hFFFF, 16'h0000, 1'b0);
        for (int i = 0; i < CORNERS; i++)
            send_request(make_request(CMD_READ, 2'(i), 4'd0, '0, '0, '0));
        send_request(make_request(CMD_READ, 2'd0, 4'd15, '0, '0, '0));
        send_request(make_request(CMD_NONE, 2'd3, 4'd0, '0, '0, '0));
        send_quad(3000000, 3000000, 50, 50, 16'h1234, 16'h8000, 1'b1);
        send_request(make_request(CMD_READ, 2'd3, 4'd1, '0, '0, '0));
        // sweep with current time behind last-seen: age wraps, everything goes
        clock_now = 32'd100;
        send_request(make_request(CMD_SWEEP, 2'd0, 4'd0, '0, '0, '0));
        clock_now = 32'hFFFF_FFF0;
        send_quad(-5000, 7000, 300, 20, 16'hFFFF, 16'hFFFF, 1'b1);
        drain_requests();
    endtask

    task automatic test_random(int n_items);
        req_t r;
        int   sent;
        int   pick;
        int   k;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 68)
            begin
                clock_now += $urandom_range(0, 400000);
                k = $urandom_range(0, 11);
                send_quad(center_x[k] + $urandom_range(0, 4000) - 2000,
                          center_y[k] + $urandom_range(0, 4000) - 2000,
                          $urandom_range(0, 9) == 0 ? $urandom_range(1, 4000000)
                                                    : $urandom_range(1, 200000),
                          $urandom_range(0, 9) == 0 ? $urandom_range(1, 4000000)
                                                    : $urandom_range(1, 200000),
                          16'($urandom), 16'($urandom), 1'($urandom));
                sent += 4;
            end
            else if (pick < 78)
            begin
                r = make_request(CMD_SWEEP, 2'($urandom), 4'($urandom), 24'($urandom),
                                 24'($urandom), 24'($urandom));
                if ($urandom_range(0, 4) == 0)
                    r.time_stamp = $urandom;
                send_request(r);
                sent++;
            end
            else if (pick < 94)
            begin
                send_request(make_request(CMD_READ, 2'($urandom), 4'($urandom),
                                          24'($urandom), 24'($urandom), 24'($urandom)));
                sent++;
            end
            else if (pick < 98)
            begin
                // stray corner, possibly closing a broken observation
                r = make_request(CMD_CORNER, 2'($urandom), 4'($urandom), 24'($urandom),
                                 24'($urandom), 24'($urandom));
                r.time_stamp = $urandom;
                send_request(r);
                sent++;
            end
            else
                send_request(make_request(CMD_NONE, 2'($urandom), 4'($urandom),
                                          24'($urandom), 24'($urandom), 24'($urandom)));
        end
    endtask

    initial
    begin
        rst_n   = 1'b0;
        start   = 1'b0;
        request = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        mismatch_count = 0;
        live_entries = 0;
        id_next = '0;
        age_limit = AGE_LIMIT_RESET;
        clock_now = '0;
        for (int i = 0; i < 12; i++)
        begin
            center_x[i] = $urandom_range(0, 8000000) - 4000000;
            center_y[i] = $urandom_range(0, 8000000) - 4000000;
        end
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random(150);
        set_age_limit(32'd0);
        test_random(120);
        set_age_limit(32'hFFFF_FFFF);
        test_random(160);
        set_age_limit(32'd300000);
        test_random(160);
        set_age_limit(32'd50000);
        test_random(140);
        drain_requests();

        if (mismatch_count == 0)
            $display("surface_map_fusion_table: match");
        else
            $display("surface_map_fusion_table: mismatch");
        $finish;
    end

    // run limit, far above the slowest legal run
    initial
    begin
        #30ms;
        $display("surface_map_fusion_table: mismatch");
        $finish;
    end

endmodule
